// ===== rtl/planar_vga_memory_access_macros.svh =====
// assertion macros shared by the planar display memory rtl
// used by files that include this header; expects clk and rst_n in scope
`ifndef PLANAR_VGA_MEMORY_ACCESS_MACROS_SVH
`define PLANAR_VGA_MEMORY_ACCESS_MACROS_SVH

// property that must hold at every clock edge outside reset
`define PVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define PVA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pva_pkg.sv =====
// types, codes and helper functions for the planar display memory block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pva_pkg;

  // access kinds carried by one item
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_GRAPHICS_MODE      = 3'd0,
    CFG_ROTATE_FUNCTION    = 3'd1,
    CFG_SET_RESET_CTRL     = 3'd2,
    CFG_CMP_COLOR          = 3'd3,
    CFG_CMP_CARE           = 3'd4,
    CFG_READ_PLANE_SELECT  = 3'd5,
    CFG_BIT_MASK           = 3'd6,
    CFG_PLANE_WRITE_ENABLE = 3'd7
  } cfg_idx_t;

  // write modes, graphics_mode bits 1:0
  typedef enum logic [1:0] {
    WMODE_ROTATE_SR = 2'd0,
    WMODE_LATCH     = 2'd1,
    WMODE_FILL      = 2'd2,
    WMODE_MASKED_SR = 2'd3
  } wmode_t;

  // raster ops, rotate_function bits 4:3
  typedef enum logic [1:0] {
    LOP_NONE = 2'd0,
    LOP_AND  = 2'd1,
    LOP_OR   = 2'd2,
    LOP_XOR  = 2'd3
  } lop_t;

  // read mode select bit inside graphics_mode
  localparam int unsigned READ_MODE_BIT = 2;

  // host-visible register file
  typedef struct packed {
    logic [2:0] graphics_mode;
    logic [4:0] rotate_function;
    logic [7:0] set_reset_ctrl;
    logic [3:0] cmp_color;
    logic [3:0] cmp_care;
    logic [1:0] read_plane_select;
    logic [7:0] bit_mask;
    logic [3:0] plane_write_enable;
  } cfg_t;

  // one host access
  typedef struct packed {
    logic        op;
    logic [15:0] address;
    logic [7:0]  write_data;
  } item_t;

  // copy one byte to all four planes
  function automatic logic [31:0] spread_byte(input logic [7:0] b);
    return {4{b}};
  endfunction

  // plane bit n set gives an all-ones byte in plane n
  function automatic logic [31:0] spread_nibble(input logic [3:0] n);
    return {{8{n[3]}}, {8{n[2]}}, {8{n[1]}}, {8{n[0]}}};
  endfunction

  // rotate a byte right
  function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] r);
    logic [15:0] w;
    w = {v, v} >> r;
    return w[7:0];
  endfunction

endpackage

// ===== rtl/pva_addr_map.sv =====
// address stage: folds the host offset onto the plane depth by reciprocal
// multiply, registered quotient then constant multiply-subtract; uses pva_pkg
`timescale 1ns / 1ps

module pva_addr_map import pva_pkg::*; #(
  parameter int PLANE_DEPTH = 65536,
  parameter int ADDR_W      = $clog2(PLANE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              s0_valid,
  input  item_t             s0_item,
  output logic              s1_valid,
  output item_t             s1_item,
  output logic [ADDR_W-1:0] s1_addr
);

  // ceil-style reciprocal, exact for 16-bit offsets at any depth in range
  localparam logic [32:0] Recip = 33'(64'h1_0000_0000 / PLANE_DEPTH + 1);

  logic        s1_valid_r;
  item_t       s1_item_r;
  logic [15:0] quot_r;
  logic [48:0] qprod;
  logic [31:0] back_prod;
  logic [15:0] rem;

  // quotient estimate from the input register
  assign qprod = 49'(s0_item.address) * 49'(Recip);

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s0_valid) begin
      s1_item_r <= s0_item;
      quot_r    <= qprod[47:32];
    end
  end

  // remainder, always below the depth
  assign back_prod = 32'(quot_r) * 32'(PLANE_DEPTH);
  assign rem       = s1_item_r.address - back_prod[15:0];

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;
  assign s1_addr  = rem[ADDR_W-1:0];

endmodule

// ===== rtl/pva_wr_form.sv =====
// write data path: write modes, set/reset, raster op and bit mask
// purely combinational; uses pva_pkg
`timescale 1ns / 1ps

module pva_wr_form import pva_pkg::*; (
  input  cfg_t        cfg,
  input  logic [7:0]  host,
  input  logic [31:0] latch,
  output logic [31:0] wdata
);

  logic [31:0] mask32;
  logic [31:0] rot32;
  logic [31:0] sr_val32;
  logic [31:0] sr_en32;
  logic [31:0] lu_data;
  logic [31:0] lu_sel;
  logic [31:0] lu_out;
  wmode_t      wmode;
  lop_t        lop;

  assign wmode    = wmode_t'(cfg.graphics_mode[1:0]);
  assign lop      = lop_t'(cfg.rotate_function[4:3]);
  assign mask32   = spread_byte(cfg.bit_mask);
  assign rot32    = spread_byte(rotr8(host, cfg.rotate_function[2:0]));
  assign sr_val32 = spread_nibble(cfg.set_reset_ctrl[3:0]);
  assign sr_en32  = spread_nibble(cfg.set_reset_ctrl[7:4]);

  // operands of the raster op per write mode
  always_comb begin
    unique case (wmode)
      WMODE_ROTATE_SR: begin
        lu_data = (rot32 & ~sr_en32) | (sr_en32 & sr_val32);
        lu_sel  = mask32;
      end
      WMODE_FILL: begin
        lu_data = spread_nibble(host[3:0]);
        lu_sel  = mask32;
      end
      WMODE_MASKED_SR: begin
        lu_data = sr_val32;
        lu_sel  = rot32 & mask32;
      end
      WMODE_LATCH: begin
        lu_data = latch;
        lu_sel  = mask32;
      end
      default: begin
        lu_data = latch;
        lu_sel  = mask32;
      end
    endcase
  end

  // raster op against the latch
  always_comb begin
    unique case (lop)
      LOP_NONE: lu_out = (lu_data & lu_sel) | (latch & ~lu_sel);
      LOP_AND:  lu_out = (lu_data | ~lu_sel) & latch;
      LOP_OR:   lu_out = (lu_data & lu_sel) | latch;
      LOP_XOR:  lu_out = (lu_data & lu_sel) ^ latch;
      default:  lu_out = latch;
    endcase
  end

  // latch copy bypasses op and mask
  assign wdata = (wmode == WMODE_LATCH) ? latch : lu_out;

endmodule

// ===== rtl/pva_store.sv =====
// plane memory: one word per offset, byte write enables, registered read,
// zero-fill sweep after reset; uses pva_pkg
`timescale 1ns / 1ps

module pva_store import pva_pkg::*; #(
  parameter int PLANE_DEPTH = 65536,
  parameter int ADDR_W      = $clog2(PLANE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [31:0]       wr_data,
  input  logic [3:0]        wr_be,
  output logic [31:0]       rd_data,
  output logic              clr_busy
);

  logic [31:0]       mem_q [PLANE_DEPTH];
  logic [31:0]       rd_data_r;
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // clear sweep control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == ADDR_W'(PLANE_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // write port, sweep has priority
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem_q[clr_addr_r] <= '0;
    end else if (wr_en) begin
      for (int p = 0; p < 4; p++) begin
        if (wr_be[p]) begin
          mem_q[addr][p*8 +: 8] <= wr_data[p*8 +: 8];
        end
      end
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_q[addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

// ===== rtl/planar_vga_memory_access.sv =====
// channel  | direction | handshake           | payload
// in_      | input     | in_valid/in_stall   | in_op, in_address, in_write_data
// out_     | output    | out_valid/out_stall | out_read_data
// cfg_     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one item per cycle sustained while the output is not stalled and no clear sweep
// runs; an item passes the input reg, quotient reg, memory port and result reg in
// order; the single memory port does one read or one byte-masked write per item.
// after reset a zero-fill sweep over all PLANE_DEPTH words runs with in_stall high;
// cfg writes still taken. a stalled output freezes the whole pipe and raises in_stall.
//
// top level of the planar display memory; depends on pva_pkg, pva_addr_map,
// pva_wr_form, pva_store and planar_vga_memory_access_macros.svh
`timescale 1ns / 1ps
`include "planar_vga_memory_access_macros.svh"

module planar_vga_memory_access import pva_pkg::*; #(
  parameter int PLANE_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int ADDR_W = $clog2(PLANE_DEPTH);

  cfg_t              cfg_r;
  logic              adv;
  logic              clr_busy;
  logic              s0_valid_r;
  item_t             s0_item_r;
  logic              s1_valid;
  item_t             s1_item;
  logic [ADDR_W-1:0] s1_addr;
  logic              s2_valid_r;
  logic              s2_op_r;
  logic [31:0]       rd_word;
  logic [31:0]       latch_r;
  logic [31:0]       latch_eff;
  logic [31:0]       wr_word;
  logic              mem_wr_en;
  logic              mem_rd_en;
  logic [31:0]       cmp_t;
  logic [7:0]        cmp_any;
  logic [7:0]        rd_byte;
  logic              out_valid_r;
  logic [7:0]        out_read_data_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.graphics_mode      <= 3'd0;
      cfg_r.rotate_function    <= 5'd0;
      cfg_r.set_reset_ctrl     <= 8'd0;
      cfg_r.cmp_color          <= 4'd0;
      cfg_r.cmp_care           <= 4'hF;
      cfg_r.read_plane_select  <= 2'd0;
      cfg_r.bit_mask           <= 8'hFF;
      cfg_r.plane_write_enable <= 4'hF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GRAPHICS_MODE:      cfg_r.graphics_mode      <= cfg_data[2:0];
        CFG_ROTATE_FUNCTION:    cfg_r.rotate_function    <= cfg_data[4:0];
        CFG_SET_RESET_CTRL:     cfg_r.set_reset_ctrl     <= cfg_data;
        CFG_CMP_COLOR:          cfg_r.cmp_color          <= cfg_data[3:0];
        CFG_CMP_CARE:           cfg_r.cmp_care           <= cfg_data[3:0];
        CFG_READ_PLANE_SELECT:  cfg_r.read_plane_select  <= cfg_data[1:0];
        CFG_BIT_MASK:           cfg_r.bit_mask           <= cfg_data;
        CFG_PLANE_WRITE_ENABLE: cfg_r.plane_write_enable <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // pipe moves as a whole whenever the output register can take an item
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv || clr_busy;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid && !clr_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s0_item_r.op         <= in_op;
      s0_item_r.address    <= in_address;
      s0_item_r.write_data <= in_write_data;
    end
  end

  // offset folding
  pva_addr_map #(
    .PLANE_DEPTH (PLANE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_addr_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s0_valid (s0_valid_r),
    .s0_item  (s0_item_r),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_addr  (s1_addr)
  );

  // latch, forwarded from a read still in the memory stage
  assign latch_eff = (s2_valid_r && (s2_op_r == OP_READ)) ? rd_word : latch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= '0;
    end else if (adv && s2_valid_r && (s2_op_r == OP_READ)) begin
      latch_r <= rd_word;
    end
  end

  // write data formation
  pva_wr_form u_wr_form (
    .cfg   (cfg_r),
    .host  (s1_item.write_data),
    .latch (latch_eff),
    .wdata (wr_word)
  );

  // memory access
  assign mem_wr_en = adv && s1_valid && (s1_item.op == OP_WRITE);
  assign mem_rd_en = adv && s1_valid && (s1_item.op == OP_READ);

  pva_store #(
    .PLANE_DEPTH (PLANE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (mem_wr_en),
    .rd_en    (mem_rd_en),
    .addr     (s1_addr),
    .wr_data  (wr_word),
    .wr_be    (cfg_r.plane_write_enable),
    .rd_data  (rd_word),
    .clr_busy (clr_busy)
  );

  // memory stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      s2_op_r <= s1_item.op;
    end
  end

  // read modes: plane byte or color compare
  assign cmp_t   = (rd_word & spread_nibble(cfg_r.cmp_care))
                 ^ spread_nibble(cfg_r.cmp_color & cfg_r.cmp_care);
  assign cmp_any = cmp_t[7:0] | cmp_t[15:8] | cmp_t[23:16] | cmp_t[31:24];

  always_comb begin
    if (cfg_r.graphics_mode[READ_MODE_BIT]) begin
      rd_byte = ~cmp_any;
    end else begin
      rd_byte = rd_word[8*cfg_r.read_plane_select +: 8];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      out_read_data_r <= (s2_op_r == OP_READ) ? rd_byte : 8'd0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;

  // checks
  `PVA_ASSERT(a_clear_blocks_input, !clr_busy || in_stall, "input open during clear sweep")
  `PVA_ASSERT(a_clear_pipe_empty, !clr_busy || (!s0_valid_r && !s1_valid && !s2_valid_r), "item in flight during clear sweep")
  `PVA_ASSERT_NEXT(a_result_held, out_valid_r && out_stall, out_valid_r, "stalled result dropped")
  `PVA_ASSERT_NEXT(a_latch_load, adv && s2_valid_r && (s2_op_r == OP_READ), latch_r == $past(rd_word), "latch missed read word")

endmodule
